@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL. Each use sits in a module that has
// clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define FIQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define FIQ_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define FIQ_ASSERT(label, prop, msg)
`define FIQ_ASSERT_NEVER(label, expr, msg)
`endif
`endif

@@ hdl/fiq_pkg.sv @@
package fiq_pkg;

   // Buttons with a run counter, and buttons wired to the panel
   localparam int BUTTON_COUNT  = 3;
   localparam int PANEL_BUTTONS = 3;
   localparam int LEFT_BUTTON   = 0;
   localparam int RIGHT_BUTTON  = 2;

   localparam int COUNTER_WIDTH = 4;
   localparam logic [COUNTER_WIDTH-1:0] COUNTER_MAX = 4'd15;

   localparam int POT_WIDTH   = 10;
   localparam int ENC_WIDTH   = 16;
   localparam int DELTA_WIDTH = ENC_WIDTH + 1;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 10;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DEBOUNCE_THRESHOLD = 1'b0,
      CSR_POT_THRESHOLD      = 1'b1
   } csr_index_type;

   localparam logic [COUNTER_WIDTH-1:0] DEBOUNCE_THRESHOLD_RESET = 4'd3;
   localparam logic [POT_WIDTH-1:0]     POT_THRESHOLD_RESET      = 10'd8;

   typedef struct packed {
      logic [PANEL_BUTTONS-1:0] fell;
      logic                     held_changed;
      logic                     switch_fell;
      logic                     switch_changed;
      logic                     combo_fell;
   } button_events_type;

   typedef struct packed {
      logic signed [DELTA_WIDTH-1:0] delta;
      logic                          delta_changed;
      logic                          pot_active;
      logic                          pot_changed;
   } motion_events_type;

endpackage

@@ hdl/fiq_buttons.sv @@
module fiq_buttons (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic [fiq_pkg::PANEL_BUTTONS-1:0]    raw,
   input  logic                                 switch_raw,
   input  logic [fiq_pkg::COUNTER_WIDTH-1:0]    threshold,
   output fiq_pkg::button_events_type           events
);

   logic [fiq_pkg::COUNTER_WIDTH-1:0] count_ff [fiq_pkg::BUTTON_COUNT];
   logic [fiq_pkg::COUNTER_WIDTH-1:0] count_in [fiq_pkg::BUTTON_COUNT];
   logic [fiq_pkg::BUTTON_COUNT-1:0]  held_ff;
   logic [fiq_pkg::BUTTON_COUNT-1:0]  held_in;
   logic [fiq_pkg::BUTTON_COUNT-1:0]  fell_all;
   logic [fiq_pkg::PANEL_BUTTONS-1:0] fell_panel;
   logic                              switch_ff;
   logic                              combo_ff;
   logic                              combo_in;

   // Per-button run counter and held level
   for (genvar g = 0; g < fiq_pkg::BUTTON_COUNT; g++) begin : g_button
      logic level;

      if (g < fiq_pkg::PANEL_BUTTONS) begin : g_wired
         assign level = raw[g];
      end else begin : g_unwired
         assign level = 1'b0;
      end

      // Count up and saturate while high, clear on low
      always_comb begin
         if (level) begin
            count_in[g] = (count_ff[g] == fiq_pkg::COUNTER_MAX) ?
                          fiq_pkg::COUNTER_MAX : count_ff[g] + 1'b1;
         end else begin
            count_in[g] = '0;
         end
         held_in[g] = count_in[g] > threshold;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            count_ff[g] <= '0;
         end else if (advance) begin
            count_ff[g] <= count_in[g];
         end
      end
   end

   assign fell_all = held_ff & ~held_in;

   // Map counted buttons onto the panel press outputs
   for (genvar p = 0; p < fiq_pkg::PANEL_BUTTONS; p++) begin : g_panel
      if (p < fiq_pkg::BUTTON_COUNT) begin : g_counted
         assign fell_panel[p] = fell_all[p];
      end else begin : g_absent
         assign fell_panel[p] = 1'b0;
      end
   end

   assign combo_in = raw[fiq_pkg::LEFT_BUTTON] & raw[fiq_pkg::RIGHT_BUTTON];

   always_comb begin
      events.fell           = fell_panel;
      events.held_changed   = held_in != held_ff;
      events.switch_fell    = switch_ff & ~switch_raw;
      events.switch_changed = switch_ff != switch_raw;
      events.combo_fell     = combo_ff & ~combo_in;
   end

   // Hold the previous frame's levels
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= '0;
         switch_ff <= 1'b0;
         combo_ff  <= 1'b0;
      end else if (advance) begin
         held_ff   <= held_in;
         switch_ff <= switch_raw;
         combo_ff  <= combo_in;
      end
   end

endmodule

@@ hdl/fiq_motion.sv @@
module fiq_motion (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  logic [fiq_pkg::POT_WIDTH-1:0]           pot_sample,
   input  logic signed [fiq_pkg::ENC_WIDTH-1:0]    encoder_count,
   input  logic [fiq_pkg::POT_WIDTH-1:0]           pot_threshold,
   output fiq_pkg::motion_events_type              events
);

   logic signed [fiq_pkg::ENC_WIDTH-1:0]   last_count_ff;
   logic signed [fiq_pkg::DELTA_WIDTH-1:0] delta_ff;
   logic signed [fiq_pkg::DELTA_WIDTH-1:0] delta_in;
   logic [fiq_pkg::POT_WIDTH-1:0]          pot_ff;
   logic [fiq_pkg::POT_WIDTH:0]            pot_sub;
   logic [fiq_pkg::POT_WIDTH:0]            pot_neg;
   logic [fiq_pkg::POT_WIDTH-1:0]          pot_diff;

   // Encoder delta: previous count minus current count, sign extended
   assign delta_in = {last_count_ff[fiq_pkg::ENC_WIDTH-1], last_count_ff}
                   - {encoder_count[fiq_pkg::ENC_WIDTH-1], encoder_count};

   // Absolute pot change
   assign pot_sub  = {1'b0, pot_sample} - {1'b0, pot_ff};
   assign pot_neg  = -pot_sub;
   assign pot_diff = pot_sub[fiq_pkg::POT_WIDTH] ? pot_neg[fiq_pkg::POT_WIDTH-1:0]
                                                 : pot_sub[fiq_pkg::POT_WIDTH-1:0];

   always_comb begin
      events.delta         = delta_in;
      events.delta_changed = delta_in != delta_ff;
      events.pot_active    = pot_diff > pot_threshold;
      events.pot_changed   = pot_sample != pot_ff;
   end

   // Hold the previous frame's encoder and pot values
   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= '0;
         delta_ff      <= '0;
         pot_ff        <= '0;
      end else if (advance) begin
         last_count_ff <= encoder_count;
         delta_ff      <= delta_in;
         pot_ff        <= pot_sample;
      end
   end

endmodule

@@ hdl/frame_input_qualifier.sv @@
// Path: a request transaction passes through the input register, then the result
// register; a stalled response channel holds the result there until it is taken.
// Throughput: one transaction per cycle while results are taken; the input register
// takes one more transaction while a result waits on a stalled response channel.
// Reset: synchronous, clears the valid flags of both registers, all frame history
// and run counters, and loads threshold defaults 3 (debounce) and 8 (pot).
`include "assert_macros.svh"

module frame_input_qualifier (
   input  logic                                        clock,
   input  logic                                        reset,

   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic                                        req_left_raw,
   input  logic                                        req_middle_raw,
   input  logic                                        req_right_raw,
   input  logic                                        req_switch_raw,
   input  logic [fiq_pkg::POT_WIDTH-1:0]               req_pot_sample,
   input  logic signed [fiq_pkg::ENC_WIDTH-1:0]        req_encoder_count,

   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic                                        rsp_active,
   output logic                                        rsp_left_pressed,
   output logic                                        rsp_middle_pressed,
   output logic                                        rsp_right_pressed,
   output logic                                        rsp_switch_pressed,
   output logic                                        rsp_reset_pressed,
   output logic                                        rsp_turned_right,
   output logic                                        rsp_turned_left,
   output logic signed [fiq_pkg::DELTA_WIDTH-1:0]      rsp_position_delta,
   output logic                                        rsp_pot_changed,
   output logic [fiq_pkg::POT_WIDTH-1:0]               rsp_pot_level,

   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [fiq_pkg::CSR_INDEX_WIDTH-1:0]         csr_index,
   input  logic [fiq_pkg::CSR_DATA_WIDTH-1:0]          csr_wdata
);

   logic [fiq_pkg::COUNTER_WIDTH-1:0]      debounce_threshold_ff;
   logic [fiq_pkg::POT_WIDTH-1:0]          pot_threshold_ff;

   logic                                   s1_valid_ff;
   logic [fiq_pkg::PANEL_BUTTONS-1:0]      s1_raw_ff;
   logic                                   s1_switch_ff;
   logic [fiq_pkg::POT_WIDTH-1:0]          s1_pot_ff;
   logic signed [fiq_pkg::ENC_WIDTH-1:0]   s1_encoder_ff;
   logic                                   s1_advance;
   logic                                   req_accept;

   logic                                   rsp_valid_ff;
   logic                                   rsp_active_ff;
   logic [fiq_pkg::PANEL_BUTTONS-1:0]      rsp_pressed_ff;
   logic                                   rsp_switch_pressed_ff;
   logic                                   rsp_reset_pressed_ff;
   logic                                   rsp_turned_right_ff;
   logic                                   rsp_turned_left_ff;
   logic signed [fiq_pkg::DELTA_WIDTH-1:0] rsp_position_delta_ff;
   logic                                   rsp_pot_changed_ff;
   logic [fiq_pkg::POT_WIDTH-1:0]          rsp_pot_level_ff;

   fiq_pkg::button_events_type             button_events;
   fiq_pkg::motion_events_type             motion_events;

   // Configuration registers: always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_threshold_ff <= fiq_pkg::DEBOUNCE_THRESHOLD_RESET;
         pot_threshold_ff      <= fiq_pkg::POT_THRESHOLD_RESET;
      end else if (csr_valid) begin
         unique case (fiq_pkg::csr_index_type'(csr_index))
            fiq_pkg::CSR_DEBOUNCE_THRESHOLD: begin
               debounce_threshold_ff <= csr_wdata[fiq_pkg::COUNTER_WIDTH-1:0];
            end
            fiq_pkg::CSR_POT_THRESHOLD: begin
               pot_threshold_ff <= csr_wdata[fiq_pkg::POT_WIDTH-1:0];
            end
         endcase
      end
   end

   // Input register advances into the result register when that is free
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Capture the request payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_raw_ff     <= {req_right_raw, req_middle_raw, req_left_raw};
         s1_switch_ff  <= req_switch_raw;
         s1_pot_ff     <= req_pot_sample;
         s1_encoder_ff <= req_encoder_count;
      end
   end

   fiq_buttons u_buttons (
      .clock      (clock),
      .reset      (reset),
      .advance    (s1_advance),
      .raw        (s1_raw_ff),
      .switch_raw (s1_switch_ff),
      .threshold  (debounce_threshold_ff),
      .events     (button_events)
   );

   fiq_motion u_motion (
      .clock         (clock),
      .reset         (reset),
      .advance       (s1_advance),
      .pot_sample    (s1_pot_ff),
      .encoder_count (s1_encoder_ff),
      .pot_threshold (pot_threshold_ff),
      .events        (motion_events)
   );

   // Result register valid: load on advance, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_active_ff         <= motion_events.delta_changed | motion_events.pot_active
                                | button_events.held_changed | button_events.switch_changed;
         rsp_pressed_ff        <= button_events.fell;
         rsp_switch_pressed_ff <= button_events.switch_fell;
         rsp_reset_pressed_ff  <= button_events.combo_fell;
         rsp_turned_right_ff   <= motion_events.delta[fiq_pkg::DELTA_WIDTH-1];
         rsp_turned_left_ff    <= !motion_events.delta[fiq_pkg::DELTA_WIDTH-1]
                                && (motion_events.delta != '0);
         rsp_position_delta_ff <= motion_events.delta;
         rsp_pot_changed_ff    <= motion_events.pot_changed;
         rsp_pot_level_ff      <= s1_pot_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_active         = rsp_active_ff;
   assign rsp_left_pressed   = rsp_pressed_ff[0];
   assign rsp_middle_pressed = rsp_pressed_ff[1];
   assign rsp_right_pressed  = rsp_pressed_ff[2];
   assign rsp_switch_pressed = rsp_switch_pressed_ff;
   assign rsp_reset_pressed  = rsp_reset_pressed_ff;
   assign rsp_turned_right   = rsp_turned_right_ff;
   assign rsp_turned_left    = rsp_turned_left_ff;
   assign rsp_position_delta = rsp_position_delta_ff;
   assign rsp_pot_changed    = rsp_pot_changed_ff;
   assign rsp_pot_level      = rsp_pot_level_ff;

   // A turn has one direction only
   `FIQ_ASSERT_NEVER(a_one_direction,
      rsp_valid_ff && rsp_turned_right_ff && rsp_turned_left_ff, "both turn directions set")
   // A debounced press is a held-level change, so it marks the frame active
   `FIQ_ASSERT(a_press_active,
      rsp_valid_ff && (rsp_pressed_ff != '0) |-> rsp_active_ff, "press without activity")
   // A waiting input transaction is kept while the result side is stalled
   `FIQ_ASSERT(a_s1_hold, s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_pot_ff),
      "input register lost a transaction")
   // An advance lands in the result register
   `FIQ_ASSERT(a_rsp_load, s1_advance |=> rsp_valid_ff, "advance did not load result")

endmodule

@@ sim/frame_input_qualifier_test.sv @@
module frame_input_qualifier_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fiq_pkg::*;

   localparam int MIDDLE_BUTTON  = 1;
   localparam int PHASE_FRAMES   = 175;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRINT_LIMIT    = 50;

   typedef struct {
      logic                        left;
      logic                        middle;
      logic                        right;
      logic                        sw;
      logic [POT_WIDTH-1:0]        pot;
      logic signed [ENC_WIDTH-1:0] enc;
   } panel_frame_type;

   typedef struct {
      logic                          active;
      logic                          left_pressed;
      logic                          middle_pressed;
      logic                          right_pressed;
      logic                          switch_pressed;
      logic                          reset_pressed;
      logic                          turned_right;
      logic                          turned_left;
      logic signed [DELTA_WIDTH-1:0] position_delta;
      logic                          pot_changed;
      logic [POT_WIDTH-1:0]          pot_level;
   } frame_events_type;

   // Debounce and edge predictor plus the queue of events it expects
   class panel_event_scoreboard;
      logic [COUNTER_WIDTH-1:0]      debounce_limit;
      logic [POT_WIDTH-1:0]          pot_limit;
      logic [COUNTER_WIDTH-1:0]      run_count[BUTTON_COUNT];
      logic signed [ENC_WIDTH-1:0]   last_count;
      logic [7:0]                    held_prior;
      logic                          switch_prior;
      logic                          combo_prior;
      logic [POT_WIDTH-1:0]          pot_prior;
      logic signed [DELTA_WIDTH-1:0] delta_prior;
      frame_events_type              expected_events[$];
      int                            errors;
      int                            results_seen;

      function new();
         debounce_limit = DEBOUNCE_THRESHOLD_RESET;
         pot_limit      = POT_THRESHOLD_RESET;
         foreach (run_count[i]) run_count[i] = '0;
         last_count   = '0;
         held_prior   = '0;
         switch_prior = 1'b0;
         combo_prior  = 1'b0;
         pot_prior    = '0;
         delta_prior  = '0;
         errors       = 0;
         results_seen = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] word);
         case (idx)
            CSR_DEBOUNCE_THRESHOLD: debounce_limit = word[COUNTER_WIDTH-1:0];
            CSR_POT_THRESHOLD:      pot_limit = word[POT_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_events.size();
      endfunction

      // Advance the frame history by one accepted frame and queue its events
      function void take_frame(panel_frame_type f);
         frame_events_type         e;
         logic [PANEL_BUTTONS-1:0] raw;
         logic [7:0]               held;
         logic [7:0]               fell;
         logic                     combo;
         logic [POT_WIDTH-1:0]     pot_diff;
         int                       enc_step;
         raw = {f.right, f.middle, f.left};
         enc_step = int'(last_count) - int'(f.enc);
         last_count = f.enc;
         held = '0;
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            // buttons beyond the panel see a constant low level
            if (i < PANEL_BUTTONS && raw[i]) begin
               if (run_count[i] != COUNTER_MAX) run_count[i] = run_count[i] + 1'b1;
            end else begin
               run_count[i] = '0;
            end
            if (i < 8) held[i] = run_count[i] > debounce_limit;
         end
         combo = raw[LEFT_BUTTON] & raw[RIGHT_BUTTON];
         pot_diff = (f.pot > pot_prior) ? f.pot - pot_prior : pot_prior - f.pot;
         fell = held_prior & ~held;

         e.position_delta = enc_step[DELTA_WIDTH-1:0];
         e.active         = (e.position_delta != delta_prior) || (pot_diff > pot_limit) ||
                            (held != held_prior) || (f.sw != switch_prior);
         e.left_pressed   = fell[LEFT_BUTTON];
         e.middle_pressed = fell[MIDDLE_BUTTON];
         e.right_pressed  = fell[RIGHT_BUTTON];
         e.switch_pressed = switch_prior & ~f.sw;
         e.reset_pressed  = combo_prior & ~combo;
         e.turned_right   = enc_step < 0;
         e.turned_left    = enc_step > 0;
         e.pot_changed    = f.pot != pot_prior;
         e.pot_level      = f.pot;
         expected_events.push_back(e);

         held_prior   = held;
         switch_prior = f.sw;
         combo_prior  = combo;
         pot_prior    = f.pot;
         delta_prior  = e.position_delta;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= PRINT_LIMIT) $display("%0t: %s", $realtime, msg);
      endtask

      task compare_field(string name, logic [DELTA_WIDTH-1:0] got,
                         logic [DELTA_WIDTH-1:0] want);
         if (got !== want)
            report($sformatf("result %0d: %s is %0h, expected %0h",
                             results_seen, name, got, want));
      endtask

      // Compare one result transaction with the oldest expected events
      task check_events(frame_events_type got);
         frame_events_type want;
         results_seen++;
         if (expected_events.size() == 0) begin
            report($sformatf("result %0d arrived with no frame outstanding", results_seen));
            return;
         end
         want = expected_events.pop_front();
         compare_field("active", got.active, want.active);
         compare_field("left_pressed", got.left_pressed, want.left_pressed);
         compare_field("middle_pressed", got.middle_pressed, want.middle_pressed);
         compare_field("right_pressed", got.right_pressed, want.right_pressed);
         compare_field("switch_pressed", got.switch_pressed, want.switch_pressed);
         compare_field("reset_pressed", got.reset_pressed, want.reset_pressed);
         compare_field("turned_right", got.turned_right, want.turned_right);
         compare_field("turned_left", got.turned_left, want.turned_left);
         compare_field("position_delta", got.position_delta, want.position_delta);
         compare_field("pot_changed", got.pot_changed, want.pot_changed);
         compare_field("pot_level", got.pot_level, want.pot_level);
      endtask
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic                          req_left_raw;
   logic                          req_middle_raw;
   logic                          req_right_raw;
   logic                          req_switch_raw;
   logic [POT_WIDTH-1:0]          req_pot_sample;
   logic signed [ENC_WIDTH-1:0]   req_encoder_count;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic                          rsp_active;
   logic                          rsp_left_pressed;
   logic                          rsp_middle_pressed;
   logic                          rsp_right_pressed;
   logic                          rsp_switch_pressed;
   logic                          rsp_reset_pressed;
   logic                          rsp_turned_right;
   logic                          rsp_turned_left;
   logic signed [DELTA_WIDTH-1:0] rsp_position_delta;
   logic                          rsp_pot_changed;
   logic [POT_WIDTH-1:0]          rsp_pot_level;
   logic                          csr_valid;
   logic                          csr_ready;
   csr_index_type                 csr_index;
   logic [CSR_DATA_WIDTH-1:0]     csr_wdata;

   panel_event_scoreboard book = new();

   // Stimulus generator state: level and remaining run per button and switch
   logic                        gen_level[4];
   int                          gen_run[4];
   int                          gen_pot;
   logic signed [ENC_WIDTH-1:0] gen_enc;
   int                          gen_stride;
   int                          burst_left;
   int                          stall_tick;
   int                          stall_mode;
   int                          idle_cycles;

   frame_input_qualifier DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_left_raw       (req_left_raw),
      .req_middle_raw     (req_middle_raw),
      .req_right_raw      (req_right_raw),
      .req_switch_raw     (req_switch_raw),
      .req_pot_sample     (req_pot_sample),
      .req_encoder_count  (req_encoder_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_active         (rsp_active),
      .rsp_left_pressed   (rsp_left_pressed),
      .rsp_middle_pressed (rsp_middle_pressed),
      .rsp_right_pressed  (rsp_right_pressed),
      .rsp_switch_pressed (rsp_switch_pressed),
      .rsp_reset_pressed  (rsp_reset_pressed),
      .rsp_turned_right   (rsp_turned_right),
      .rsp_turned_left    (rsp_turned_left),
      .rsp_position_delta (rsp_position_delta),
      .rsp_pot_changed    (rsp_pot_changed),
      .rsp_pot_level      (rsp_pot_level),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // Check result transactions and stall the response channel in changing patterns
   always @(posedge clock) begin : receiver
      frame_events_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.active         = rsp_active;
         got.left_pressed   = rsp_left_pressed;
         got.middle_pressed = rsp_middle_pressed;
         got.right_pressed  = rsp_right_pressed;
         got.switch_pressed = rsp_switch_pressed;
         got.reset_pressed  = rsp_reset_pressed;
         got.turned_right   = rsp_turned_right;
         got.turned_left    = rsp_turned_left;
         got.position_delta = rsp_position_delta;
         got.pot_changed    = rsp_pot_changed;
         got.pot_level      = rsp_pot_level;
         book.check_events(got);
      end
      stall_tick++;
      if (stall_tick % 64 == 0) stall_mode = $urandom_range(3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(1));
         2: rsp_ready <= (stall_tick % 4 == 0);
         default: rsp_ready <= (stall_tick % 16) < 4;
      endcase
   end

   // End the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $realtime, idle_cycles);
         $display("FAIL frame_input_qualifier");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic panel_frame_type frame_of(logic l, logic m, logic r, logic s,
                                                logic [POT_WIDTH-1:0] pot,
                                                logic signed [ENC_WIDTH-1:0] enc);
      panel_frame_type f;
      f.left   = l;
      f.middle = m;
      f.right  = r;
      f.sw     = s;
      f.pot    = pot;
      f.enc    = enc;
      return f;
   endfunction

   // Run lengths: bounces, runs right around the threshold, and saturating runs
   function automatic int pick_run();
      int limit;
      limit = int'(book.debounce_limit);
      case ($urandom_range(3))
         0: return 1 + $urandom_range(2);
         1: return limit + $urandom_range(2);
         2: return 1 + $urandom_range(25);
         default: return 1 + $urandom_range(6);
      endcase
   endfunction

   function automatic panel_frame_type make_frame();
      panel_frame_type f;
      int              swing;
      // occasional noise frame with every field random
      if ($urandom_range(11) == 0) begin
         f = frame_of(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                      POT_WIDTH'($urandom), ENC_WIDTH'($urandom));
         return f;
      end
      for (int b = 0; b < 4; b++) begin
         if (gen_run[b] <= 0) begin
            gen_level[b] = ~gen_level[b];
            gen_run[b] = pick_run();
         end
         gen_run[b]--;
      end
      case ($urandom_range(4))
         0, 1: ;
         2: begin
            swing = int'(book.pot_limit) + $urandom_range(2) - 1;
            gen_pot += $urandom_range(1) ? swing : -swing;
         end
         3: gen_pot += $urandom_range(6) - 3;
         default: gen_pot = $urandom_range(1023);
      endcase
      if (gen_pot < 0) gen_pot = 0;
      if (gen_pot > 1023) gen_pot = 1023;
      // a repeated stride keeps the delta steady, so frames can be quiet
      case ($urandom_range(5))
         0, 1, 2: gen_enc = gen_enc + ENC_WIDTH'(gen_stride);
         3: begin
            gen_stride = $urandom_range(8) - 4;
            gen_enc = gen_enc + ENC_WIDTH'(gen_stride);
         end
         4: gen_enc = ENC_WIDTH'($urandom);
         default: gen_enc = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      endcase
      f = frame_of(gen_level[0], gen_level[1], gen_level[2], gen_level[3],
                   POT_WIDTH'(gen_pot), gen_enc);
      return f;
   endfunction

   // Send one frame transaction; bursts of random length with random gaps
   task automatic transmit(input panel_frame_type f);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_left_raw      <= f.left;
      req_middle_raw    <= f.middle;
      req_right_raw     <= f.right;
      req_switch_raw    <= f.sw;
      req_pot_sample    <= f.pot;
      req_encoder_count <= f.enc;
      do @(posedge clock); while (!req_ready);
      book.take_frame(f);
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(input logic [CSR_DATA_WIDTH-1:0] debounce_word,
                                  input logic [CSR_DATA_WIDTH-1:0] pot_word);
      csr_valid <= 1'b1;
      csr_index <= CSR_DEBOUNCE_THRESHOLD;
      csr_wdata <= debounce_word;
      do @(posedge clock); while (!csr_ready);
      book.set_register(CSR_DEBOUNCE_THRESHOLD, debounce_word);
      csr_index <= CSR_POT_THRESHOLD;
      csr_wdata <= pot_word;
      do @(posedge clock); while (!csr_ready);
      book.set_register(CSR_POT_THRESHOLD, pot_word);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int count);
      repeat (count) transmit(make_frame());
   endtask

   task automatic next_setting(input logic [CSR_DATA_WIDTH-1:0] debounce_word,
                               input logic [CSR_DATA_WIDTH-1:0] pot_word);
      settle();
      write_registers(debounce_word, pot_word);
      run_random(PHASE_FRAMES);
   endtask

   initial begin
      panel_frame_type directed[$];
      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_left_raw      = 1'b0;
      req_middle_raw    = 1'b0;
      req_right_raw     = 1'b0;
      req_switch_raw    = 1'b0;
      req_pot_sample    = '0;
      req_encoder_count = '0;
      rsp_ready         = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = CSR_DEBOUNCE_THRESHOLD;
      csr_wdata         = '0;
      idle_cycles       = 0;
      burst_left        = 0;
      stall_tick        = 0;
      stall_mode        = 0;
      gen_pot           = 512;
      gen_enc           = '0;
      gen_stride        = 1;
      foreach (gen_level[b]) begin
         gen_level[b] = 1'b0;
         gen_run[b]   = 0;
      end

      // Directed frames under the reset thresholds (debounce 3, pot 8)
      directed.push_back(frame_of(1'b0, 1'b0, 1'b0, 1'b0, 10'd0, 16'sh0000));
      // all buttons and switch high; encoder and pot at their extremes
      directed.push_back(frame_of(1'b1, 1'b1, 1'b1, 1'b1, 10'd1023, 16'sh7FFF));
      directed.push_back(frame_of(1'b1, 1'b1, 1'b1, 1'b1, 10'd1023, 16'sh8000));
      // pot change equal to the threshold, then one more
      directed.push_back(frame_of(1'b1, 1'b1, 1'b1, 1'b1, 10'd1015, 16'sh7FFF));
      directed.push_back(frame_of(1'b1, 1'b1, 1'b1, 1'b1, 10'd1006, 16'sh7FFF));
      // release everything: all presses, switch and left-right combination
      directed.push_back(frame_of(1'b0, 1'b0, 1'b0, 1'b0, 10'd0, 16'sh7FFF));
      // combination falls without any held button
      directed.push_back(frame_of(1'b1, 1'b0, 1'b1, 1'b0, 10'd0, 16'sh0000));
      directed.push_back(frame_of(1'b0, 1'b0, 1'b1, 1'b0, 10'd0, 16'sh0000));
      directed.push_back(frame_of(1'b0, 1'b0, 1'b0, 1'b1, 10'd0, 16'sh0000));
      directed.push_back(frame_of(1'b0, 1'b0, 1'b0, 1'b0, 10'd0, 16'sh0000));
      // middle alone held, then released
      repeat (5) directed.push_back(frame_of(1'b0, 1'b1, 1'b0, 1'b0, 10'd512, 16'sh0000));
      directed.push_back(frame_of(1'b0, 1'b0, 1'b0, 1'b0, 10'd512, 16'sh0000));
      // left high exactly as long as the threshold: never held
      repeat (3) directed.push_back(frame_of(1'b1, 1'b0, 1'b0, 1'b0, 10'd512, 16'sh0000));
      directed.push_back(frame_of(1'b0, 1'b0, 1'b0, 1'b0, 10'd512, 16'sh0000));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) transmit(directed[i]);
      run_random(PHASE_FRAMES);

      // threshold extremes, a threshold the counter can never pass, masked data
      next_setting(10'd0, 10'd0);
      next_setting(10'd14, 10'd1023);
      next_setting(10'd15, 10'd512);
      next_setting(10'h3F5, 10'h155);
      next_setting(10'($urandom), 10'($urandom));
      next_setting(10'd3, 10'd8);
      next_setting(10'd1, 10'd1);
      settle();

      if (book.errors == 0 && book.pending() == 0) begin
         $display("PASS frame_input_qualifier");
      end else begin
         $display("FAIL frame_input_qualifier");
      end
      $finish;
   end

endmodule
